// ----- rtl/cte_pkg.sv -----
// ----------------------------------------------------------------------------
// cte_pkg
// Shared types and constants for the modular exponentiation block.
// ----------------------------------------------------------------------------
package cte_pkg;

    // Width of every field on the item ports
    localparam int IN_BITS = 32;

    // Per-cycle control for one double-and-add cell
    typedef struct packed {
        logic clear;    // drop the partial result to zero
        logic step;     // advance by one multiplier bit
        logic bit_in;   // multiplier bit for this step, most significant first
    } cte_cell_ctrl_t;

endpackage

// ----- rtl/cte_cell.sv -----
// ----------------------------------------------------------------------------
// cte_cell
// One modular double-and-add cell: r <= (2r + bit*a) mod m, r < m held inside.
// ----------------------------------------------------------------------------
module cte_cell
    import cte_pkg::*;
#(
    parameter int W = 32
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  cte_cell_ctrl_t ctrl,
    input  logic [W-1:0]   addend,
    input  logic [W-1:0]   modulus,
    output logic [W-1:0]   partial
);

    logic [W-1:0] r_reg;
    logic [W-1:0] r_next;
    logic [W:0]   dbl;
    logic [W-1:0] dbl_red;
    logic [W:0]   sum;
    logic [W:0]   mod_ext;

    always_comb
    begin
        mod_ext = {1'b0, modulus};
        dbl     = {r_reg, 1'b0};
        if (dbl >= mod_ext)
        begin
            dbl_red = W'(dbl - mod_ext);
        end
        else
        begin
            dbl_red = dbl[W-1:0];
        end
        sum = {1'b0, dbl_red} + {1'b0, addend};
        if (!ctrl.bit_in)
        begin
            r_next = dbl_red;
        end
        else if (sum >= mod_ext)
        begin
            r_next = W'(sum - mod_ext);
        end
        else
        begin
            r_next = sum[W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            r_reg <= '0;
        end
        else if (ctrl.clear)
        begin
            r_reg <= '0;
        end
        else if (ctrl.step)
        begin
            r_reg <= r_next;
        end
    end

    assign partial = r_reg;

endmodule

// ----- rtl/constant_time_modular_exponentiation_top.sv -----
// ----------------------------------------------------------------------------
// constant_time_modular_exponentiation_top
// Right-to-left square-and-multiply with a fixed schedule per exponent bit.
// ----------------------------------------------------------------------------
// Flow: ST_REDUCE reduces the base, then ST_MULT and ST_UPDATE run for every exponent
//   bit before ST_FINISH; a bad modulus goes from the accept straight to ST_FINISH.
// Items: one item at a time; the next item is accepted only once the block is back
//   in idle, after ST_FINISH has handed over the result.
// Reset: asynchronous, active low; returns to idle with no result pending.
module constant_time_modular_exponentiation_top
    import cte_pkg::*;
#(
    parameter int MOD_BITS = 32,
    parameter int EXP_BITS = 32
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [IN_BITS-1:0]  base_value,
    input  logic [IN_BITS-1:0]  exponent_value,
    input  logic [IN_BITS-1:0]  modulus_value,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [IN_BITS-1:0]  power_result,
    output logic                bad_modulus
);

    localparam int W      = MOD_BITS;
    localparam int E      = EXP_BITS;
    localparam int MAXW   = (W > IN_BITS) ? W : IN_BITS;
    localparam int CW     = $clog2(MAXW);
    localparam int EW     = $clog2(E);

    // Sequencer codes
    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_REDUCE = 3'd1;
    localparam logic [2:0] ST_MULT   = 3'd2;
    localparam logic [2:0] ST_UPDATE = 3'd3;
    localparam logic [2:0] ST_FINISH = 3'd4;

    logic [2:0]         state_reg, state_next;
    logic [CW-1:0]      cnt_reg, cnt_next;
    logic [EW-1:0]      bit_cnt_reg, bit_cnt_next;
    logic               first_reg, first_next;
    logic               bad_reg, bad_next;
    logic [W-1:0]       mod_reg, mod_next;
    logic [IN_BITS-1:0] base_reg, base_next;
    logic [E-1:0]       exp_reg, exp_next;
    logic [W-1:0]       sq_reg, sq_next;
    logic [W-1:0]       acc_reg, acc_next;
    logic [W-1:0]       bsq_reg, bsq_next;
    logic [W-1:0]       bacc_reg, bacc_next;
    logic               out_valid_reg, out_valid_next;
    logic [IN_BITS-1:0] result_reg, result_next;
    logic               bad_out_reg, bad_out_next;

    cte_cell_ctrl_t     sq_ctrl, mul_ctrl;
    logic [W-1:0]       sq_addend;
    logic [W-1:0]       sq_part, mul_part;

    logic [W+IN_BITS-1:0] mod_wide;
    logic [E+IN_BITS-1:0] exp_wide;
    logic [W+IN_BITS-1:0] acc_wide;
    logic [W-1:0]         mod_in;
    logic                 accept;
    logic                 out_free;

    // Fit the 32-bit fields to the parameter widths: mask or zero-extend
    assign mod_wide = {{W{1'b0}}, modulus_value};
    assign exp_wide = {{E{1'b0}}, exponent_value};
    assign acc_wide = {{IN_BITS{1'b0}}, acc_reg};
    assign mod_in   = mod_wide[W-1:0];

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;

    // Square lane: reduces the base first (addend 1), then squares
    assign sq_addend = (state_reg == ST_REDUCE) ? W'(1) : sq_reg;

    cte_cell #(.W(W)) u_sq_cell
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (sq_ctrl),
        .addend  (sq_addend),
        .modulus (mod_reg),
        .partial (sq_part)
    );

    // Multiply lane: acc * sq, kept only where the exponent bit is set
    cte_cell #(.W(W)) u_mul_cell
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (mul_ctrl),
        .addend  (sq_reg),
        .modulus (mod_reg),
        .partial (mul_part)
    );

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        bit_cnt_next   = bit_cnt_reg;
        first_next     = first_reg;
        bad_next       = bad_reg;
        mod_next       = mod_reg;
        base_next      = base_reg;
        exp_next       = exp_reg;
        sq_next        = sq_reg;
        acc_next       = acc_reg;
        bsq_next       = bsq_reg;
        bacc_next      = bacc_reg;
        out_valid_next = out_valid_reg;
        result_next    = result_reg;
        bad_out_next   = bad_out_reg;
        sq_ctrl        = '0;
        mul_ctrl       = '0;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    mod_next     = mod_in;
                    base_next    = base_value;
                    exp_next     = exp_wide[E-1:0];
                    bad_next     = (mod_in < W'(2));
                    cnt_next     = '0;
                    bit_cnt_next = '0;
                    first_next   = 1'b1;
                    sq_ctrl.clear  = 1'b1;
                    mul_ctrl.clear = 1'b1;
                    state_next   = (mod_in < W'(2)) ? ST_FINISH : ST_REDUCE;
                end
            end

            ST_REDUCE:
            begin
                // base mod m, one base bit per cycle from the top
                sq_ctrl.step   = 1'b1;
                sq_ctrl.bit_in = base_reg[IN_BITS-1];
                base_next      = {base_reg[IN_BITS-2:0], 1'b0};
                cnt_next       = cnt_reg + CW'(1);
                if (cnt_reg == CW'(IN_BITS-1))
                begin
                    cnt_next   = '0;
                    state_next = ST_UPDATE;
                end
            end

            ST_MULT:
            begin
                sq_ctrl.step    = 1'b1;
                sq_ctrl.bit_in  = bsq_reg[W-1];
                mul_ctrl.step   = 1'b1;
                mul_ctrl.bit_in = bacc_reg[W-1];
                bsq_next        = {bsq_reg[W-2:0], 1'b0};
                bacc_next       = {bacc_reg[W-2:0], 1'b0};
                cnt_next        = cnt_reg + CW'(1);
                if (cnt_reg == CW'(W-1))
                begin
                    cnt_next   = '0;
                    state_next = ST_UPDATE;
                end
            end

            ST_UPDATE:
            begin
                // Latch lane results, reload operands for the next exponent bit
                sq_ctrl.clear  = 1'b1;
                mul_ctrl.clear = 1'b1;
                sq_next        = sq_part;
                bsq_next       = sq_part;
                first_next     = 1'b0;
                if (first_reg)
                begin
                    acc_next   = W'(1);
                    bacc_next  = W'(1);
                    state_next = ST_MULT;
                end
                else
                begin
                    if (exp_reg[0])
                    begin
                        acc_next  = mul_part;
                        bacc_next = mul_part;
                    end
                    else
                    begin
                        bacc_next = acc_reg;
                    end
                    exp_next     = exp_reg >> 1;
                    bit_cnt_next = bit_cnt_reg + EW'(1);
                    state_next   = (bit_cnt_reg == EW'(E-1)) ? ST_FINISH : ST_MULT;
                end
            end

            ST_FINISH:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    result_next    = bad_reg ? '0 : acc_wide[IN_BITS-1:0];
                    bad_out_next   = bad_reg;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            bit_cnt_reg   <= '0;
            first_reg     <= 1'b0;
            bad_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            bit_cnt_reg   <= bit_cnt_next;
            first_reg     <= first_next;
            bad_reg       <= bad_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Datapath holds, no reset needed
    always_ff @(posedge clk)
    begin
        mod_reg     <= mod_next;
        base_reg    <= base_next;
        exp_reg     <= exp_next;
        sq_reg      <= sq_next;
        acc_reg     <= acc_next;
        bsq_reg     <= bsq_next;
        bacc_reg    <= bacc_next;
        result_reg  <= result_next;
        bad_out_reg <= bad_out_next;
    end

    assign out_valid    = out_valid_reg;
    assign power_result = result_reg;
    assign bad_modulus  = bad_out_reg;

endmodule

// ----- rtl/cte_checker.sv -----
// ----------------------------------------------------------------------------
// cte_assertions
// Port-level checks for the modular exponentiation block.
// ----------------------------------------------------------------------------
module cte_assertions
    import cte_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input logic [IN_BITS-1:0] power_result,
    input logic               bad_modulus
);

    // A bad modulus always comes with a zero result
    a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && bad_modulus |-> power_result == '0)
        else $error("bad modulus with nonzero result");

    // One item at a time: busy right after an accept
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("accepted a second item while busy");

    // A stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(power_result)
            && $stable(bad_modulus))
        else $error("result changed while stalled");

endmodule

bind constant_time_modular_exponentiation_top cte_assertions u_cte_assertions
(
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .power_result (power_result),
    .bad_modulus  (bad_modulus)
);
